FILE: hdl/sbf_pkg.sv
package sbf_pkg;

	localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIXER  = 64'hBF58476D1CE4E5B9;

	localparam int MAX_HASHES_DEF = 16;
	localparam int MAX_SLICES_DEF = 8;
	localparam int MAX_BITS_DEF   = 1048576;

	localparam int HASH_W    = 64;
	localparam int BYTE_W    = 8;
	localparam int BPI_W     = 7;
	localparam int HC_W      = 5;
	localparam int ICAP_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 17;
	localparam int CNT_W     = 32;
	localparam int SLCNT_W   = 4;
	localparam int NBITS_W   = 21;
	localparam int WORD_W    = 64;
	localparam int WSEL_W    = 6;
	localparam int MOD_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_ITEM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP      = 2'd2;

	localparam logic [BPI_W-1:0]  BPI_RST  = 7'd10;
	localparam logic [BPI_W-1:0]  BPI_MAX  = 7'd64;
	localparam logic [HC_W-1:0]   HC_RST   = 5'd7;
	localparam logic [ICAP_W-1:0] ICAP_RST = 17'd1024;
	localparam logic [ICAP_W-1:0] ICAP_MAX = 17'd65536;
	localparam logic [CNT_W-1:0]  CNT_SAT  = '1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	function automatic logic [HASH_W-1:0] lane_seed(input int unsigned idx);
		logic [HASH_W-1:0] v;
		v = HASH_W'(idx) * GOLDEN;
		return v;
	endfunction

	typedef struct packed {
		logic clr_run;
		logic accept;
		logic hash_issue;
		logic li_clr;
		logic li_inc;
		logic si_cur;
		logic si_clr;
		logic si_inc;
		logic mod_load;
		logic mod_step;
		logic pos_load;
		logic mem_rd;
		logic mem_set;
		logic count_insert;
		logic grow_calc;
		logic grow_open;
		logic found_set;
		logic res_fire;
	} sbf_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic valid_q;
		logic last_q;
		logic kind_q;
		logic hash_last;
		logic li_next_done;
		logic mod_done;
		logic bit_set;
		logic si_done;
		logic need_grow;
	} sbf_stat_t;

endpackage

FILE: hdl/sbf_ctrl.sv
module sbf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output sbf_pkg::sbf_cmd_t cmd,
	input  sbf_pkg::sbf_stat_t st
);
	import sbf_pkg::*;

	typedef enum logic [14:0] {
		S_CLEAR    = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_DISPATCH = 15'b000000000000100,
		S_HASH     = 15'b000000000001000,
		S_HDRAIN   = 15'b000000000010000,
		S_FIN      = 15'b000000000100000,
		S_QCHK     = 15'b000000001000000,
		S_MODLD    = 15'b000000010000000,
		S_MODRUN   = 15'b000000100000000,
		S_POS      = 15'b000001000000000,
		S_MRD      = 15'b000010000000000,
		S_MTST     = 15'b000100000000000,
		S_GROW1    = 15'b001000000000000,
		S_GROW2    = 15'b010000000000000,
		S_DONE     = 15'b100000000000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (st.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.li_clr = 1'b1;
				if (st.valid_q) state_nxt = S_HASH;
				else if (st.last_q) state_nxt = S_FIN;
				else state_nxt = S_IDLE;
			end
			S_HASH: begin
				cmd.hash_issue = 1'b1;
				cmd.li_inc = 1'b1;
				if (st.hash_last) state_nxt = S_HDRAIN;
			end
			S_HDRAIN: begin
				if (st.last_q) state_nxt = S_FIN;
				else state_nxt = S_IDLE;
			end
			S_FIN: begin
				cmd.li_clr = 1'b1;
				if (st.kind_q == KIND_INSERT) begin
					cmd.count_insert = 1'b1;
					cmd.si_cur = 1'b1;
					state_nxt = S_MODLD;
				end else begin
					cmd.si_clr = 1'b1;
					state_nxt = S_QCHK;
				end
			end
			S_QCHK: begin
				if (st.si_done) state_nxt = S_DONE;
				else state_nxt = S_MODLD;
			end
			S_MODLD: begin
				cmd.mod_load = 1'b1;
				state_nxt = S_MODRUN;
			end
			S_MODRUN: begin
				cmd.mod_step = 1'b1;
				if (st.mod_done) state_nxt = S_POS;
			end
			S_POS: begin
				cmd.pos_load = 1'b1;
				state_nxt = S_MRD;
			end
			S_MRD: begin
				cmd.mem_rd = 1'b1;
				state_nxt = S_MTST;
			end
			S_MTST: begin
				if (st.kind_q == KIND_INSERT) begin
					cmd.mem_set = 1'b1;
					cmd.li_inc = 1'b1;
					if (!st.li_next_done) state_nxt = S_MODLD;
					else if (st.need_grow) state_nxt = S_GROW1;
					else state_nxt = S_DONE;
				end else if (!st.bit_set) begin
					// miss in this slice, move to the next one
					cmd.si_inc = 1'b1;
					cmd.li_clr = 1'b1;
					state_nxt = S_QCHK;
				end else if (st.li_next_done) begin
					cmd.found_set = 1'b1;
					state_nxt = S_DONE;
				end else begin
					cmd.li_inc = 1'b1;
					state_nxt = S_MODLD;
				end
			end
			S_GROW1: begin
				cmd.grow_calc = 1'b1;
				state_nxt = S_GROW2;
			end
			S_GROW2: begin
				cmd.grow_open = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				cmd.res_fire = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/sbf_datapath.sv
module sbf_datapath #(
	parameter int MAX_HASHES = sbf_pkg::MAX_HASHES_DEF,
	parameter int MAX_SLICES = sbf_pkg::MAX_SLICES_DEF,
	parameter int MAX_BITS   = sbf_pkg::MAX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kind,
	input  logic [sbf_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          byte_valid,
	input  logic                          last_byte,
	input  logic                          cfg_we,
	input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbf_pkg::CFG_W-1:0]     cfg_data,
	input  sbf_pkg::sbf_cmd_t             cmd,
	output sbf_pkg::sbf_stat_t            st,
	output logic                          done,
	output logic                          found,
	output logic [sbf_pkg::CNT_W-1:0]     total_inserts,
	output logic [sbf_pkg::SLCNT_W-1:0]   slice_count,
	output logic                          scaled,
	output logic [sbf_pkg::NBITS_W-1:0]   new_slice_bits,
	output logic                          storage_full
);
	import sbf_pkg::*;

	localparam int LW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int HW    = $clog2(MAX_HASHES + 1);
	localparam int SIW   = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int NW    = $clog2(MAX_SLICES + 1);
	localparam int SW    = $clog2(MAX_BITS + 1);
	localparam int PW    = $clog2(MAX_BITS);
	localparam int AW    = PW - WSEL_W;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = ICAP_W + MAX_SLICES - 1;
	localparam int GW    = CW + 1 + BPI_W;
	localparam int B0W   = BPI_W + ICAP_W;
	localparam int SUMW  = ((GW > SW + 1) ? GW : SW + 1) + 1;

	// configuration registers and their clamped values
	logic [BPI_W-1:0]  bpi_q;
	logic [HC_W-1:0]   hc_q;
	logic [ICAP_W-1:0] icap_q;
	logic [BPI_W-1:0]  bpi_eff;
	logic [HW-1:0]     hc_eff;
	logic [ICAP_W-1:0] cap_eff;
	logic [B0W-1:0]    bits0_prod;
	logic [SW-1:0]     bits0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpi_q  <= BPI_RST;
			hc_q   <= HC_RST;
			icap_q <= ICAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BITS_PER_ITEM: bpi_q  <= cfg_data[BPI_W-1:0];
				REG_HASH_COUNT:    hc_q   <= cfg_data[HC_W-1:0];
				REG_INIT_CAP:      icap_q <= cfg_data[ICAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bpi_q == '0) bpi_eff = BPI_W'(1);
		else if (bpi_q > BPI_MAX) bpi_eff = BPI_MAX;
		else bpi_eff = bpi_q;
		if (hc_q == '0) hc_eff = HW'(1);
		else if (int'(hc_q) > MAX_HASHES) hc_eff = HW'(MAX_HASHES);
		else hc_eff = HW'(hc_q);
		if (icap_q == '0) cap_eff = ICAP_W'(1);
		else if (icap_q > ICAP_MAX) cap_eff = ICAP_MAX;
		else cap_eff = icap_q;
	end

	assign bits0_prod = B0W'(bpi_eff) * B0W'(cap_eff);

	always_ff @(posedge clk) begin
		if (int'(bits0_prod) > MAX_BITS) bits0_q <= SW'(MAX_BITS);
		else bits0_q <= SW'(bits0_prod);
	end

	// latched request
	logic               kind_q;
	logic               valid_q;
	logic               last_q;
	logic [BYTE_W-1:0]  byte_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= kind;
			valid_q <= byte_valid;
			last_q  <= last_byte;
			byte_q  <= data_byte;
		end
	end

	// loop indexes
	logic [HW-1:0] li_q;
	logic [NW-1:0] si_q;
	logic [NW-1:0] in_use_q;
	logic [SIW-1:0] cur_idx;
	logic [SIW-1:0] si_idx;

	assign cur_idx = SIW'(in_use_q - NW'(1));
	assign si_idx  = si_q[SIW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			li_q <= '0;
			si_q <= '0;
		end else begin
			if (cmd.li_clr) li_q <= '0;
			else if (cmd.li_inc) li_q <= li_q + HW'(1);
			if (cmd.si_clr) si_q <= '0;
			else if (cmd.si_cur) si_q <= NW'(cur_idx);
			else if (cmd.si_inc) si_q <= si_q + NW'(1);
		end
	end

	// hash lanes, one lane per cycle through a split 64-bit multiply
	logic [HASH_W-1:0] lanes_q [MAX_HASHES];
	logic [HASH_W-1:0] lane_rd;
	logic [HASH_W-1:0] mix_x;
	logic [63:0]       m0;
	logic [63:0]       m1;
	logic [63:0]       m2;
	logic [63:0]       p0_s1;
	logic [31:0]       p1_s1;
	logic [31:0]       p2_s1;
	logic [LW-1:0]     idx_s1;
	logic              v_s1;
	logic [HASH_W-1:0] mix_y;
	logic [HASH_W-1:0] mix_z;

	assign lane_rd = lanes_q[li_q[LW-1:0]];
	assign mix_x   = lane_rd ^ HASH_W'(byte_q);
	assign m0 = 64'(mix_x[31:0]) * 64'(MIXER[31:0]);
	assign m1 = 64'(mix_x[31:0]) * 64'(MIXER[63:32]);
	assign m2 = 64'(mix_x[63:32]) * 64'(MIXER[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.hash_issue;
		end
	end

	always_ff @(posedge clk) begin
		p0_s1  <= m0;
		p1_s1  <= m1[31:0];
		p2_s1  <= m2[31:0];
		idx_s1 <= li_q[LW-1:0];
	end

	assign mix_y = p0_s1 + {p1_s1 + p2_s1, 32'b0};
	assign mix_z = mix_y ^ (mix_y >> 31);

	for (genvar i = 0; i < MAX_HASHES; i++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lanes_q[i] <= lane_seed(i);
			end else if (cmd.res_fire) begin
				lanes_q[i] <= lane_seed(i);
			end else if (v_s1 && (idx_s1 == LW'(i))) begin
				lanes_q[i] <= mix_z;
			end
		end
	end

	// slice table
	logic [SW-1:0]    base_q [MAX_SLICES];
	logic [SW-1:0]    size_q [MAX_SLICES];
	logic [CW-1:0]    cap_q  [MAX_SLICES];
	logic [HW-1:0]    hash_q [MAX_SLICES];
	logic [CNT_W-1:0] ins_q  [MAX_SLICES];
	logic [CNT_W-1:0] total_q;
	logic [CW:0]      capn_q;
	logic [GW-1:0]    bitsn_q;
	logic [SW:0]      basen_q;
	logic [SUMW-1:0]  endn;
	logic             fit;
	logic             refresh0;
	logic             found_q;
	logic             scaled_q;
	logic             full_q;
	logic [NBITS_W-1:0] nb_q;
	logic             done_q;

	assign refresh0 = (in_use_q == NW'(1)) && (ins_q[0] == '0);
	assign endn = SUMW'(basen_q) + SUMW'(bitsn_q);
	assign fit  = (int'(in_use_q) < MAX_SLICES) && (endn <= SUMW'(MAX_BITS));

	always_ff @(posedge clk) begin
		// slice zero follows the registers until its first insert
		if (refresh0) begin
			base_q[0] <= '0;
			size_q[0] <= bits0_q;
			cap_q[0]  <= CW'(cap_eff);
			hash_q[0] <= hc_eff;
		end
		if (cmd.grow_calc) begin
			capn_q  <= {cap_q[cur_idx], 1'b0};
			bitsn_q <= GW'(bpi_eff) * GW'({cap_q[cur_idx], 1'b0});
			basen_q <= (SW + 1)'(base_q[cur_idx]) + (SW + 1)'(size_q[cur_idx]);
		end
		if (cmd.grow_open && fit) begin
			base_q[SIW'(in_use_q)] <= SW'(basen_q);
			size_q[SIW'(in_use_q)] <= SW'(bitsn_q);
			cap_q[SIW'(in_use_q)]  <= CW'(capn_q);
			hash_q[SIW'(in_use_q)] <= hc_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLICES; s++) ins_q[s] <= '0;
			in_use_q <= NW'(1);
			total_q  <= '0;
			found_q  <= 1'b0;
			scaled_q <= 1'b0;
			full_q   <= 1'b0;
			nb_q     <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.res_fire;
			if (cmd.accept) begin
				found_q  <= 1'b0;
				scaled_q <= 1'b0;
				full_q   <= 1'b0;
				nb_q     <= '0;
			end
			if (cmd.found_set) found_q <= 1'b1;
			if (cmd.count_insert) begin
				if (ins_q[cur_idx] != CNT_SAT) ins_q[cur_idx] <= ins_q[cur_idx] + CNT_W'(1);
				if (total_q != CNT_SAT) total_q <= total_q + CNT_W'(1);
			end
			if (cmd.grow_open) begin
				if (fit) begin
					ins_q[SIW'(in_use_q)] <= '0;
					in_use_q <= in_use_q + NW'(1);
					scaled_q <= 1'b1;
					nb_q     <= NBITS_W'(bitsn_q);
				end else begin
					full_q <= 1'b1;
				end
			end
		end
	end

	// remainder unit, one dividend bit per cycle
	logic [HASH_W-1:0]    dvd_q;
	logic [SW-1:0]        rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SW:0]          rem_t;
	logic [SW:0]          size_x;

	assign rem_t  = {rem_q, dvd_q[HASH_W-1]};
	assign size_x = {1'b0, size_q[si_idx]};

	always_ff @(posedge clk) begin
		if (cmd.mod_load) begin
			dvd_q <= lane_rd;
			rem_q <= '0;
			cnt_q <= '1;
		end else if (cmd.mod_step) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q - MOD_CNT_W'(1);
			if (rem_t >= size_x) rem_q <= SW'(rem_t - size_x);
			else rem_q <= SW'(rem_t);
		end
	end

	// filter bit memory, cleared word by word after reset
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [PW-1:0]     pos_q;
	logic [AW-1:0]     clr_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [WORD_W-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (cmd.pos_load) pos_q <= PW'((SW + 1)'(base_q[si_idx]) + (SW + 1)'(rem_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_run) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_comb begin
		mem_we = cmd.clr_run || cmd.mem_set;
		if (cmd.clr_run) begin
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_wa = pos_q[PW-1:WSEL_W];
			mem_wd = rd_q | (WORD_W'(1) << pos_q[WSEL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.mem_rd) rd_q <= mem[pos_q[PW-1:WSEL_W]];
	end

	always_comb begin
		st.clr_last     = &clr_q;
		st.valid_q      = valid_q;
		st.last_q       = last_q;
		st.kind_q       = kind_q;
		st.hash_last    = (li_q == HW'(MAX_HASHES - 1));
		st.li_next_done = (({1'b0, li_q} + (HW + 1)'(1)) >= {1'b0, hash_q[si_idx]});
		st.mod_done     = (cnt_q == '0);
		st.bit_set      = rd_q[pos_q[WSEL_W-1:0]];
		st.si_done      = (si_q >= in_use_q);
		st.need_grow    = (ins_q[cur_idx] >= CNT_W'(cap_q[cur_idx]));
	end

	assign done           = done_q;
	assign found          = found_q;
	assign total_inserts  = total_q;
	assign slice_count    = SLCNT_W'(in_use_q);
	assign scaled         = scaled_q;
	assign new_slice_bits = nb_q;
	assign storage_full   = full_q;

endmodule

FILE: hdl/scalable_bloom_filter_core.sv
// byte step: every lane is hashed in turn by the shared lane multiplier (one lane per cycle)
// key end: each hashed bit probed runs the bit-serial remainder unit, a position load,
// a memory read and a bit test, plus GROW1 and GROW2 for slice growth; a result strobe
// follows on done for one cycle; one request in flight at a time; start is taken while busy
// is low, results cannot stall; after reset the filter memory is cleared one 64-bit word
// per cycle with busy high; configuration writes are taken during that pass
module scalable_bloom_filter_core #(
	parameter int MAX_HASHES = sbf_pkg::MAX_HASHES_DEF,
	parameter int MAX_SLICES = sbf_pkg::MAX_SLICES_DEF,
	parameter int MAX_BITS   = sbf_pkg::MAX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [sbf_pkg::BYTE_W-1:0]    data_byte,
	input  logic                          byte_valid,
	input  logic                          last_byte,
	input  logic                          cfg_we,
	input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbf_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output logic                          found,
	output logic [sbf_pkg::CNT_W-1:0]     total_inserts,
	output logic [sbf_pkg::SLCNT_W-1:0]   slice_count,
	output logic                          scaled,
	output logic [sbf_pkg::NBITS_W-1:0]   new_slice_bits,
	output logic                          storage_full
);
	import sbf_pkg::*;

	sbf_cmd_t  cmd;
	sbf_stat_t st;

	sbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.st     (st)
	);

	sbf_datapath #(
		.MAX_HASHES (MAX_HASHES),
		.MAX_SLICES (MAX_SLICES),
		.MAX_BITS   (MAX_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.last_byte      (last_byte),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.st             (st),
		.done           (done),
		.found          (found),
		.total_inserts  (total_inserts),
		.slice_count    (slice_count),
		.scaled         (scaled),
		.new_slice_bits (new_slice_bits),
		.storage_full   (storage_full)
	);

endmodule
